@@ sv/p2a_pkg.sv @@
`timescale 1ns / 1ps

package p2a_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH = 1'd1;
	localparam int CFG_DATA_W = 11;
	localparam logic [10:0] GRID_WIDTH_RESET = 11'd80;

	// Ramp characters defined, darkest first
	localparam int RAMP_DEFINED = 10;

	// Fixed text bytes
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_8 = 8'h38;

	// Input word: one sampled pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Output word: one text byte
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_of_run;
	} text_t;

	// Configuration as seen by the front
	typedef struct packed {
		logic        color_mode;
		logic [10:0] grid_width;
	} cfg_t;

	// Decimal digits of one color component
	typedef struct packed {
		logic       has_h;
		logic       has_t;
		logic [1:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	// One classified pixel, handed from front to back
	typedef struct packed {
		logic       color;
		logic       row_end;
		logic [7:0] ch;
		digits_t    rd;
		digits_t    gd;
		digits_t    bd;
	} job_t;

	function automatic logic [7:0] ramp_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = 8'h20;
			4'd1: c = 8'h2E;
			4'd2: c = 8'h3A;
			4'd3: c = 8'h2D;
			4'd4: c = 8'h3D;
			4'd5: c = 8'h2B;
			4'd6: c = 8'h2A;
			4'd7: c = 8'h23;
			4'd8: c = 8'h25;
			default: c = 8'h40;
		endcase
		return c;
	endfunction

	// Split a byte into decimal digits with independent compares
	function automatic digits_t to_digits(input logic [7:0] v);
		digits_t d;
		logic [7:0] rem;
		logic [3:0] t;
		d.hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		rem = v - 8'(d.hund) * 8'd100;
		t = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (rem >= 8'(k * 10)) t = 4'(k);
		end
		d.tens = t;
		d.ones = 4'(rem - 8'(t) * 8'd10);
		d.has_h = (v >= 8'd100);
		d.has_t = (v >= 8'd10);
		return d;
	endfunction

endpackage

@@ sv/p2a_front.sv @@
`timescale 1ns / 1ps

module p2a_front #(
	parameter int MAX_COLUMNS = 1024,
	parameter int RAMP_SIZE = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  p2a_pkg::pixel_t in_word,
	input  p2a_pkg::cfg_t   cfg,
	output logic            job_valid,
	input  logic            job_ready,
	output p2a_pkg::job_t   job
);

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CMPW = (CW + 2 > 12) ? CW + 2 : 12;
	localparam int XW = $clog2(255 * (RAMP_SIZE - 1) + 1) + 1;

	logic             valid_s1;
	logic [7:0]       luma_s1;
	logic             color_s1;
	logic             row_end_s1;
	p2a_pkg::digits_t rd_s1, gd_s1, bd_s1;
	logic [CW-1:0]    col_q;

	logic             accept;
	logic [23:0]      luma_sum;
	logic [CMPW-1:0]  eff_w;
	logic             row_end;

	assign in_stall = valid_s1 && !job_ready;
	assign accept   = in_valid && !in_stall;

	// Q16 luma
	assign luma_sum = 24'd19595 * {16'd0, in_word.red}
		+ 24'd38470 * {16'd0, in_word.green}
		+ 24'd7471 * {16'd0, in_word.blue} + 24'd32768;

	// Effective row width, clamped to 1..MAX_COLUMNS
	always_comb begin
		if (cfg.grid_width == 11'd0) begin
			eff_w = CMPW'(1);
		end else if (CMPW'(cfg.grid_width) > CMPW'(MAX_COLUMNS)) begin
			eff_w = CMPW'(MAX_COLUMNS);
		end else begin
			eff_w = CMPW'(cfg.grid_width);
		end
	end

	assign row_end = (CMPW'(col_q) + CMPW'(1)) >= eff_w;

	// Column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept) begin
			col_q <= row_end ? '0 : col_q + CW'(1);
		end
	end

	// Stage 1: luma, digits and row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1    <= luma_sum[23:16];
			color_s1   <= cfg.color_mode;
			row_end_s1 <= row_end;
			rd_s1      <= p2a_pkg::to_digits(in_word.red);
			gd_s1      <= p2a_pkg::to_digits(in_word.green);
			bd_s1      <= p2a_pkg::to_digits(in_word.blue);
		end
	end

	// Ramp index: luma*(RAMP_SIZE-1)/255 by reciprocal and one correction
	logic [XW-1:0] prod, q0, q, rem;
	logic [3:0]    idx;

	always_comb begin
		prod = XW'(luma_s1) * XW'(RAMP_SIZE - 1);
		q0   = (prod + (prod >> 8)) >> 8;
		rem  = prod - q0 * XW'(255);
		q    = (rem >= XW'(255)) ? q0 + XW'(1) : q0;
		if (q >= XW'(p2a_pkg::RAMP_DEFINED)) begin
			idx = 4'(p2a_pkg::RAMP_DEFINED - 1);
		end else begin
			idx = 4'(q);
		end
	end

	assign job_valid   = valid_s1;
	assign job.color   = color_s1;
	assign job.row_end = row_end_s1;
	assign job.ch      = p2a_pkg::ramp_char(idx);
	assign job.rd      = rd_s1;
	assign job.gd      = gd_s1;
	assign job.bd      = bd_s1;

endmodule

@@ sv/p2a_queue.sv @@
`timescale 1ns / 1ps

module p2a_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  p2a_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_pop,
	output p2a_pkg::job_t rd_job
);

	p2a_pkg::job_t mem_q [2];
	logic          wptr_q, rptr_q;
	logic [1:0]    count_q;
	logic          do_wr, do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;
	assign rd_job   = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) wptr_q <= !wptr_q;
			if (do_rd) rptr_q <= !rptr_q;
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_job;
	end

endmodule

@@ sv/p2a_back.sv @@
`timescale 1ns / 1ps

module p2a_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_pop,
	input  p2a_pkg::job_t  job,
	output logic           out_valid,
	input  logic           out_stall,
	output p2a_pkg::text_t out_word
);

	// Byte positions of one cell's text
	typedef enum logic [24:0] {
		SL_ESC     = 25'h0000001,
		SL_LBR     = 25'h0000002,
		SL_3       = 25'h0000004,
		SL_8       = 25'h0000008,
		SL_SEMI0   = 25'h0000010,
		SL_2       = 25'h0000020,
		SL_SEMI1   = 25'h0000040,
		SL_RH      = 25'h0000080,
		SL_RT      = 25'h0000100,
		SL_RO      = 25'h0000200,
		SL_SEMI2   = 25'h0000400,
		SL_GH      = 25'h0000800,
		SL_GT      = 25'h0001000,
		SL_GO      = 25'h0002000,
		SL_SEMI3   = 25'h0004000,
		SL_BH      = 25'h0008000,
		SL_BT      = 25'h0010000,
		SL_BO      = 25'h0020000,
		SL_M       = 25'h0040000,
		SL_CHAR    = 25'h0080000,
		SL_RST_ESC = 25'h0100000,
		SL_RST_LBR = 25'h0200000,
		SL_RST_0   = 25'h0400000,
		SL_RST_M   = 25'h0800000,
		SL_NL      = 25'h1000000
	} slot_t;

	slot_t          slot_q;
	logic           fresh_q;
	logic           out_valid_q;
	p2a_pkg::text_t out_q;

	slot_t          cur, nxt;
	logic           last;
	logic [7:0]     byte_v;
	logic           load, emit;

	// A new job starts at its first slot
	assign cur = fresh_q ? (job.color ? SL_ESC : SL_CHAR) : slot_q;

	// Next slot, skipping leading zeros and the reset sequence
	always_comb begin
		unique case (cur)
			SL_SEMI1: nxt = job.rd.has_h ? SL_RH : (job.rd.has_t ? SL_RT : SL_RO);
			SL_SEMI2: nxt = job.gd.has_h ? SL_GH : (job.gd.has_t ? SL_GT : SL_GO);
			SL_SEMI3: nxt = job.bd.has_h ? SL_BH : (job.bd.has_t ? SL_BT : SL_BO);
			SL_CHAR:  nxt = job.color ? SL_RST_ESC : SL_NL;
			default:  nxt = slot_t'({cur[23:0], 1'b0});
		endcase
	end

	assign last = (cur == SL_CHAR && !job.row_end) || (cur == SL_NL);

	// Byte at the current slot
	always_comb begin
		unique case (cur) inside
			SL_ESC, SL_RST_ESC:                 byte_v = p2a_pkg::CH_ESC;
			SL_LBR, SL_RST_LBR:                 byte_v = p2a_pkg::CH_LBR;
			SL_3:                               byte_v = p2a_pkg::CH_3;
			SL_8:                               byte_v = p2a_pkg::CH_8;
			SL_2:                               byte_v = p2a_pkg::CH_2;
			SL_SEMI0, SL_SEMI1, SL_SEMI2, SL_SEMI3: byte_v = p2a_pkg::CH_SEMI;
			SL_RH: byte_v = p2a_pkg::CH_0 | {6'd0, job.rd.hund};
			SL_RT: byte_v = p2a_pkg::CH_0 | {4'd0, job.rd.tens};
			SL_RO: byte_v = p2a_pkg::CH_0 | {4'd0, job.rd.ones};
			SL_GH: byte_v = p2a_pkg::CH_0 | {6'd0, job.gd.hund};
			SL_GT: byte_v = p2a_pkg::CH_0 | {4'd0, job.gd.tens};
			SL_GO: byte_v = p2a_pkg::CH_0 | {4'd0, job.gd.ones};
			SL_BH: byte_v = p2a_pkg::CH_0 | {6'd0, job.bd.hund};
			SL_BT: byte_v = p2a_pkg::CH_0 | {4'd0, job.bd.tens};
			SL_BO: byte_v = p2a_pkg::CH_0 | {4'd0, job.bd.ones};
			SL_M, SL_RST_M:                     byte_v = p2a_pkg::CH_M;
			SL_CHAR:                            byte_v = job.ch;
			SL_RST_0:                           byte_v = p2a_pkg::CH_0;
			SL_NL:                              byte_v = p2a_pkg::CH_NL;
			default:                            byte_v = p2a_pkg::CH_NL;
		endcase
	end

	assign load    = !out_valid_q || !out_stall;
	assign emit    = load && job_valid;
	assign job_pop = emit && last;

	// Slot sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			slot_q  <= SL_ESC;
		end else if (emit) begin
			fresh_q <= last;
			slot_q  <= nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.text_byte   <= byte_v;
			out_q.last_of_run <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

@@ sv/pixel_to_ascii_text_renderer.sv @@
`timescale 1ns / 1ps

// Pixel to text renderer with a ten-step luminance ramp and optional
// 24-bit ANSI foreground color.
// Input channel: one RGB pixel word per handshake (in_valid / in_stall),
// in raster order. Output channel: one text byte word per handshake
// (out_valid / out_stall); last_of_run marks the final byte of a pixel.
// Configuration: cfg_we with cfg_index / cfg_data writes color_mode or
// grid_width; write only while the block is idle.
// The first byte of a pixel passes the luma stage, the job queue and then
// the output register before out_valid rises.
// Throughput: one output byte per cycle while the receiver does not stall,
// set by the back-end byte sequencer. A pixel gives 1 byte in plain mode
// (2 at row end) and 14 to 20 bytes in color mode (19 to 25 at row end),
// depending on the digit counts of its components. The front accepts one
// pixel per cycle until the two-entry job queue fills.
// Reset clears the column counter, sets color_mode to 0 and grid_width to
// 80, and empties the pipeline. When the receiver stalls, the output word
// holds and the front keeps accepting until the queue is full.
module pixel_to_ascii_text_renderer #(
	parameter int MAX_COLUMNS = 1024,
	parameter int RAMP_SIZE = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  p2a_pkg::pixel_t                  in_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output p2a_pkg::text_t                   out_word,
	input  logic                             cfg_we,
	input  logic [p2a_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [p2a_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic          color_q;
	logic [10:0]   width_q;
	p2a_pkg::cfg_t cfg;

	logic          fj_valid, fj_ready;
	p2a_pkg::job_t fj;
	logic          bj_valid, bj_pop;
	p2a_pkg::job_t bj;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 1'b0;
			width_q <= p2a_pkg::GRID_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				p2a_pkg::REG_COLOR_MODE: color_q <= cfg_data[0];
				p2a_pkg::REG_GRID_WIDTH: width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.color_mode = color_q;
	assign cfg.grid_width = width_q;

	p2a_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.RAMP_SIZE   (RAMP_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.cfg       (cfg),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj)
	);

	p2a_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fj_valid),
		.wr_ready (fj_ready),
		.wr_job   (fj),
		.rd_valid (bj_valid),
		.rd_pop   (bj_pop),
		.rd_job   (bj)
	);

	p2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_pop   (bj_pop),
		.job       (bj),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

@@ tb/sv/pixel_to_ascii_text_renderer_tb.sv @@
`timescale 1ns / 1ps

module pixel_to_ascii_text_renderer_tb;

	localparam int GRID_MAX = 1024;
	localparam int RAMP_STEPS = 10;
	localparam logic [7:0] RAMP_GLYPHS [RAMP_STEPS] =
		'{" ", ".", ":", "-", "=", "+", "*", "#", "%", "@"};

	// Text predictor plus queue of expected text words
	class text_scoreboard;
		p2a_pkg::text_t expected_text[$];
		logic [7:0]     burst[$];
		bit             color_on;
		logic [10:0]    width_reg;
		logic [9:0]     column;
		int             errors;
		int             pixels;
		int             bytes_seen;
		int             row_ends;

		function new();
			color_on = 1'b0;
			width_reg = p2a_pkg::GRID_WIDTH_RESET;
			column = '0;
			errors = 0;
			pixels = 0;
			bytes_seen = 0;
			row_ends = 0;
		endfunction

		function void write_reg(logic [p2a_pkg::CFG_INDEX_W-1:0] idx, logic [10:0] value);
			if (idx == p2a_pkg::REG_COLOR_MODE)
				color_on = value[0];
			else if (idx == p2a_pkg::REG_GRID_WIDTH)
				width_reg = value;
		endfunction

		// Decimal text of one component, no leading zeros
		function void add_decimal(logic [7:0] v);
			if (v >= 8'd100)
				burst.push_back(p2a_pkg::CH_0 + v / 8'd100);
			if (v >= 8'd10)
				burst.push_back(p2a_pkg::CH_0 + (v / 8'd10) % 8'd10);
			burst.push_back(p2a_pkg::CH_0 + v % 8'd10);
		endfunction

		// Accepted pixel: build its expected text run
		function void note_pixel(p2a_pkg::pixel_t p);
			int unsigned luma;
			int unsigned level;
			int unsigned cells;
			p2a_pkg::text_t t;
			pixels++;
			burst.delete();
			luma = (32'd19595 * p.red + 32'd38470 * p.green + 32'd7471 * p.blue
				+ 32'd32768) >> 16;
			level = luma * (RAMP_STEPS - 1) / 255;
			if (level > RAMP_STEPS - 1)
				level = RAMP_STEPS - 1;
			cells = 32'(width_reg);
			if (cells < 1)
				cells = 1;
			if (cells > GRID_MAX)
				cells = GRID_MAX;
			if (color_on) begin
				burst.push_back(p2a_pkg::CH_ESC);
				burst.push_back(p2a_pkg::CH_LBR);
				burst.push_back(p2a_pkg::CH_3);
				burst.push_back(p2a_pkg::CH_8);
				burst.push_back(p2a_pkg::CH_SEMI);
				burst.push_back(p2a_pkg::CH_2);
				burst.push_back(p2a_pkg::CH_SEMI);
				add_decimal(p.red);
				burst.push_back(p2a_pkg::CH_SEMI);
				add_decimal(p.green);
				burst.push_back(p2a_pkg::CH_SEMI);
				add_decimal(p.blue);
				burst.push_back(p2a_pkg::CH_M);
			end
			burst.push_back(RAMP_GLYPHS[level]);
			// row end: color reset in color mode, then newline
			if (int'(column) + 1 >= int'(cells)) begin
				if (color_on) begin
					burst.push_back(p2a_pkg::CH_ESC);
					burst.push_back(p2a_pkg::CH_LBR);
					burst.push_back(p2a_pkg::CH_0);
					burst.push_back(p2a_pkg::CH_M);
				end
				burst.push_back(p2a_pkg::CH_NL);
				column = '0;
				row_ends++;
			end else begin
				column = column + 10'd1;
			end
			foreach (burst[k]) begin
				t.text_byte = burst[k];
				t.last_of_run = (k == burst.size() - 1);
				expected_text.push_back(t);
			end
		endfunction

		// Accepted text word against the oldest expectation
		function void check_text(p2a_pkg::text_t got);
			p2a_pkg::text_t want;
			bytes_seen++;
			if (expected_text.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual byte %h last %b",
					$time, got.text_byte, got.last_of_run);
				return;
			end
			want = expected_text.pop_front();
			if (got.text_byte !== want.text_byte) begin
				errors++;
				$display("%0t: text_byte mismatch, expected %h actual %h",
					$time, want.text_byte, got.text_byte);
			end
			if (got.last_of_run !== want.last_of_run) begin
				errors++;
				$display("%0t: last_of_run mismatch, expected %b actual %b",
					$time, want.last_of_run, got.last_of_run);
			end
		endfunction

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	p2a_pkg::pixel_t                 in_word = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	p2a_pkg::text_t                  out_word;
	logic                            cfg_we = 1'b0;
	logic [p2a_pkg::CFG_INDEX_W-1:0] cfg_index = p2a_pkg::REG_COLOR_MODE;
	logic [p2a_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	text_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	bit hold_go = 1'b0;
	int hold_left = 0;

	pixel_to_ascii_text_renderer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#4000000;
		$display("pixel_to_ascii_text_renderer_tb failed");
		$finish;
	end

	// Receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left = hold_len;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_text(out_word);
	end

	// Offer one pixel word, with random idle cycles ahead of it
	task automatic send_pixel(p2a_pkg::pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_pixel(p);
	endtask

	task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		p2a_pkg::pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		send_pixel(p);
	endtask

	// Wait until every expected word is out and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Both registers, back to back; junk in the unused color bits
	task automatic set_config(bit color, logic [10:0] width);
		logic [10:0] color_word;
		color_word = {10'($urandom), color};
		cfg_we <= 1'b1;
		cfg_index <= p2a_pkg::REG_COLOR_MODE;
		cfg_data <= color_word;
		@(posedge clk);
		sb.write_reg(p2a_pkg::REG_COLOR_MODE, color_word);
		cfg_index <= p2a_pkg::REG_GRID_WIDTH;
		cfg_data <= width;
		@(posedge clk);
		sb.write_reg(p2a_pkg::REG_GRID_WIDTH, width);
		cfg_we <= 1'b0;
	endtask

	// Component biased toward digit-count boundaries
	function automatic logic [7:0] pick_component();
		logic [7:0] corners [8] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd199,
			8'd200, 8'd255};
		if ($urandom_range(3) == 0)
			return corners[$urandom_range(7)];
		return 8'($urandom);
	endfunction

	function automatic logic [10:0] pick_width();
		case ($urandom_range(4))
			0: return 11'd1;
			1: return 11'($urandom_range(2, 6));
			2: return 11'($urandom_range(7, 40));
			3: return 11'd1024;
			default: return 11'($urandom);
		endcase
	endfunction

	initial begin
		int idle_sender [5] = '{0, 78, 0, 18, 0};
		int idle_recv [5] = '{0, 0, 78, 18, 0};
		logic [7:0] grays [10] = '{8'd0, 8'd29, 8'd57, 8'd85, 8'd114, 8'd142,
			8'd170, 8'd199, 8'd227, 8'd255};
		p2a_pkg::pixel_t p;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset config: plain, 80 cells; one gray per ramp step, then red, green, blue
		foreach (grays[k])
			send_rgb(grays[k], grays[k], grays[k]);
		send_rgb(8'd255, 8'd0, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd0, 8'd255);

		// Color, width 3 below the current column: first pixel ends the row
		drain();
		set_config(1'b1, 11'd3);
		send_rgb(8'd0, 8'd9, 8'd10);
		send_rgb(8'd99, 8'd100, 8'd199);
		send_rgb(8'd200, 8'd254, 8'd255);
		send_rgb(8'd255, 8'd255, 8'd255);
		send_rgb(8'd1, 8'd0, 8'd0);

		// Width zero counts as one cell
		drain();
		set_config(1'b1, 11'd0);
		send_rgb(8'd128, 8'd64, 8'd32);
		send_rgb(8'd255, 8'd255, 8'd255);

		// Width above the maximum clamps
		drain();
		set_config(1'b0, 11'd2047);
		send_rgb(8'd0, 8'd0, 8'd0);
		send_rgb(8'd77, 8'd150, 8'd29);

		// Random phases, each with its own config and idling mix
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			set_config(1'($urandom_range(1)), pick_width());
			send_idle_pct = idle_sender[ph];
			recv_stall_pct = idle_recv[ph];
			if (ph == 4) begin
				hold_len = 80;
				hold_go = 1'b1;
			end
			repeat (22) begin
				p.red = pick_component();
				p.green = pick_component();
				p.blue = pick_component();
				send_pixel(p);
			end
		end

		drain();
		$display("%0d pixels and %0d text words checked, %0d row ends seen,",
			sb.pixels, sb.bytes_seen, sb.row_ends);
		$display("plain and color modes, widths from 0 to 2047, idle and stall mixes");
		if (sb.errors == 0) begin
			$display("pixel_to_ascii_text_renderer_tb passed");
		end else begin
			$display("pixel_to_ascii_text_renderer_tb failed");
		end
		$finish;
	end

endmodule
